@@ design/swept_circle_collision_filter_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the swept circle collision filter
// Implication checks, same-cycle and next-cycle.
// ---------------------------------------------------------------------------
`ifndef SWEPT_CIRCLE_COLLISION_FILTER_ASSERT_SVH
`define SWEPT_CIRCLE_COLLISION_FILTER_ASSERT_SVH

`define SCCF_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

`define SCCF_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/sccf_pkg.sv @@
// ---------------------------------------------------------------------------
// sccf_pkg
// Types and register codes shared by the collision filter modules.
// ---------------------------------------------------------------------------
package sccf_pkg;

  localparam int AddrW = 5;

  typedef enum logic [2:0] {
    REG_A_CUR_X  = 3'd0,
    REG_A_CUR_Y  = 3'd1,
    REG_A_PREV_X = 3'd2,
    REG_A_PREV_Y = 3'd3,
    REG_A_RAD    = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic signed [23:0] ax;
    logic signed [23:0] ay;
    logic signed [23:0] apx;
    logic signed [23:0] apy;
    logic [15:0]        arad;
  } ref_circle_t;

  typedef struct packed {
    logic               mode;
    logic               dz;
    logic [49:0]        d2;
    logic [51:0]        den;
    logic signed [51:0] num;
    logic [49:0]        e2;
    logic [33:0]        r2;
  } geom_t;

endpackage

@@ design/sccf_cfg.sv @@
// ---------------------------------------------------------------------------
// sccf_cfg
// Register file holding the reference circle, written over the APB port.
// ---------------------------------------------------------------------------
module sccf_cfg
  import sccf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrW-1:0]    paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output ref_circle_t         ref_o
);

  ref_circle_t ref_r;
  ref_circle_t ref_nxt;
  reg_idx_t    idx;
  logic        wr;

  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign ref_o  = ref_r;

  always_comb begin
    ref_nxt = ref_r;
    if (wr) begin
      case (idx)
        REG_A_CUR_X:  ref_nxt.ax   = pwdata[23:0];
        REG_A_CUR_Y:  ref_nxt.ay   = pwdata[23:0];
        REG_A_PREV_X: ref_nxt.apx  = pwdata[23:0];
        REG_A_PREV_Y: ref_nxt.apy  = pwdata[23:0];
        REG_A_RAD:    ref_nxt.arad = pwdata[15:0];
        default:      ref_nxt = ref_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_A_CUR_X:  prdata = {8'd0, ref_r.ax};
      REG_A_CUR_Y:  prdata = {8'd0, ref_r.ay};
      REG_A_PREV_X: prdata = {8'd0, ref_r.apx};
      REG_A_PREV_Y: prdata = {8'd0, ref_r.apy};
      REG_A_RAD:    prdata = {16'd0, ref_r.arad};
      default:      prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r <= '0;
    end else begin
      ref_r <= ref_nxt;
    end
  end

endmodule

@@ design/sccf_geom.sv @@
// ---------------------------------------------------------------------------
// sccf_geom
// Three stages: coordinate differences, squares and cross products, sums.
// ---------------------------------------------------------------------------
module sccf_geom
  import sccf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  ref_circle_t        ref_i,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_mode,
  input  logic signed [23:0] in_b_cur_x,
  input  logic signed [23:0] in_b_cur_y,
  input  logic signed [23:0] in_b_prev_x,
  input  logic signed [23:0] in_b_prev_y,
  input  logic [15:0]        in_b_rad,
  output logic               out_valid,
  input  logic               out_ready,
  output geom_t              out_geom
);

  logic v1_r, v2_r, v3_r;
  logic adv1, adv2, adv3;

  logic               mode1_r;
  logic signed [24:0] dfx_r, dfy_r, dx_r, dy_r;
  logic signed [25:0] dirx_r, diry_r;
  logic [16:0]        r_r;

  logic               mode2_r, dz2_r;
  logic [48:0]        dfx2_r, dfy2_r, dx2_r, dy2_r;
  logic [50:0]        dirx2_r, diry2_r;
  logic signed [50:0] crx_r, cry_r;
  logic [33:0]        r2_r;

  logic signed [49:0] dfx2_w, dfy2_w, dx2_w, dy2_w;
  logic signed [51:0] dirx2_w, diry2_w;

  geom_t g3_r;

  assign adv3      = !v3_r || out_ready;
  assign adv2      = !v2_r || adv3;
  assign adv1      = !v1_r || adv2;
  assign in_ready  = adv1;
  assign out_valid = v3_r;
  assign out_geom  = g3_r;

  assign dfx2_w  = dfx_r * dfx_r;
  assign dfy2_w  = dfy_r * dfy_r;
  assign dx2_w   = dx_r * dx_r;
  assign dy2_w   = dy_r * dy_r;
  assign dirx2_w = dirx_r * dirx_r;
  assign diry2_w = diry_r * diry_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      mode1_r <= in_mode;
      dfx_r   <= ref_i.apx - in_b_prev_x;
      dfy_r   <= ref_i.apy - in_b_prev_y;
      dx_r    <= ref_i.ax - in_b_cur_x;
      dy_r    <= ref_i.ay - in_b_cur_y;
      dirx_r  <= ref_i.apx + in_b_cur_x - ref_i.ax - in_b_prev_x;
      diry_r  <= ref_i.apy + in_b_cur_y - ref_i.ay - in_b_prev_y;
      r_r     <= {1'b0, ref_i.arad} + {1'b0, in_b_rad};
    end
    if (adv2) begin
      mode2_r <= mode1_r;
      dz2_r   <= (dirx_r == 26'sd0) && (diry_r == 26'sd0);
      dfx2_r  <= dfx2_w[48:0];
      dfy2_r  <= dfy2_w[48:0];
      dx2_r   <= dx2_w[48:0];
      dy2_r   <= dy2_w[48:0];
      dirx2_r <= dirx2_w[50:0];
      diry2_r <= diry2_w[50:0];
      crx_r   <= dfx_r * dirx_r;
      cry_r   <= dfy_r * diry_r;
      r2_r    <= {17'd0, r_r} * {17'd0, r_r};
    end
    if (adv3) begin
      g3_r.mode <= mode2_r;
      g3_r.dz   <= dz2_r;
      g3_r.d2   <= {1'b0, dfx2_r} + {1'b0, dfy2_r};
      g3_r.e2   <= {1'b0, dx2_r} + {1'b0, dy2_r};
      g3_r.den  <= {1'b0, dirx2_r} + {1'b0, diry2_r};
      g3_r.num  <= {crx_r[50], crx_r} + {cry_r[50], cry_r};
      g3_r.r2   <= r2_r;
    end
  end

endmodule

@@ design/sccf_decide.sv @@
// ---------------------------------------------------------------------------
// sccf_decide
// Four stages: case flags, split products, product sums, hit select.
// ---------------------------------------------------------------------------
`include "swept_circle_collision_filter_assert.svh"

module sccf_decide
  import sccf_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  geom_t in_geom,
  output logic  out_valid,
  input  logic  out_ready,
  output logic  out_hit
);

  logic v4_r, v5_r, v6_r, v7_r;
  logic adv4, adv5, adv6, adv7;

  logic        mode4_r, dz4_r, start4_r, end4_r, d2le4_r, e2le4_r;
  logic [49:0] dd4_r;
  logic [51:0] den4_r;
  logic [50:0] nu4_r;

  logic        mode5_r, dz5_r, start5_r, end5_r, d2le5_r, e2le5_r;
  logic [51:0] pl_ll_r, pl_lh_r, pr_ll_r;
  logic [49:0] pl_hl_r, pl_hh_r, pr_hh_r;
  logic [50:0] pr_lh_r;

  logic         mode6_r, dz6_r, start6_r, end6_r, d2le6_r, e2le6_r;
  logic [101:0] lhs6_r, rhs6_r;

  logic hit_r, hit_nxt;

  assign adv7      = !v7_r || out_ready;
  assign adv6      = !v6_r || adv7;
  assign adv5      = !v5_r || adv6;
  assign adv4      = !v4_r || adv5;
  assign in_ready  = adv4;
  assign out_valid = v7_r;
  assign out_hit   = hit_r;

  always_comb begin
    if (!mode6_r) begin
      hit_nxt = e2le6_r;
    end else if (dz6_r || start6_r) begin
      hit_nxt = d2le6_r;
    end else if (end6_r) begin
      hit_nxt = e2le6_r;
    end else begin
      hit_nxt = d2le6_r || (lhs6_r <= rhs6_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else begin
      if (adv4) v4_r <= in_valid;
      if (adv5) v5_r <= v4_r;
      if (adv6) v6_r <= v5_r;
      if (adv7) v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      mode4_r  <= in_geom.mode;
      dz4_r    <= in_geom.dz;
      start4_r <= in_geom.num[51] || (in_geom.num == 52'sd0);
      end4_r   <= $signed({in_geom.num[51], in_geom.num}) >= $signed({1'b0, in_geom.den});
      d2le4_r  <= in_geom.d2 <= {16'd0, in_geom.r2};
      e2le4_r  <= in_geom.e2 <= {16'd0, in_geom.r2};
      dd4_r    <= in_geom.d2 - {16'd0, in_geom.r2};
      den4_r   <= in_geom.den;
      nu4_r    <= in_geom.num[50:0];
    end
    if (adv5) begin
      mode5_r  <= mode4_r;
      dz5_r    <= dz4_r;
      start5_r <= start4_r;
      end5_r   <= end4_r;
      d2le5_r  <= d2le4_r;
      e2le5_r  <= e2le4_r;
      pl_ll_r  <= {26'd0, dd4_r[25:0]} * {26'd0, den4_r[25:0]};
      pl_lh_r  <= {26'd0, dd4_r[25:0]} * {26'd0, den4_r[51:26]};
      pl_hl_r  <= {26'd0, dd4_r[49:26]} * {24'd0, den4_r[25:0]};
      pl_hh_r  <= {26'd0, dd4_r[49:26]} * {24'd0, den4_r[51:26]};
      pr_ll_r  <= {26'd0, nu4_r[25:0]} * {26'd0, nu4_r[25:0]};
      pr_lh_r  <= {25'd0, nu4_r[25:0]} * {26'd0, nu4_r[50:26]};
      pr_hh_r  <= {25'd0, nu4_r[50:26]} * {25'd0, nu4_r[50:26]};
    end
    if (adv6) begin
      mode6_r  <= mode5_r;
      dz6_r    <= dz5_r;
      start6_r <= start5_r;
      end6_r   <= end5_r;
      d2le6_r  <= d2le5_r;
      e2le6_r  <= e2le5_r;
      lhs6_r   <= {pl_hh_r, 52'd0} + {24'd0, pl_lh_r, 26'd0}
                + {26'd0, pl_hl_r, 26'd0} + {50'd0, pl_ll_r};
      rhs6_r   <= {pr_hh_r, 52'd0} + {24'd0, pr_lh_r, 27'd0}
                + {50'd0, pr_ll_r};
    end
    if (adv7) begin
      hit_r <= hit_nxt;
    end
  end

  `SCCF_ASSERT_NOW(a_no_drop, clk, rst_n, !in_ready, v4_r && v5_r && v6_r && v7_r, "request dropped")
  `SCCF_ASSERT_NEXT(a_hold_out, clk, rst_n, v7_r && !out_ready, v7_r && $stable(hit_r), "result lost")
  `SCCF_ASSERT_NOW(a_one_path, clk, rst_n, v5_r && mode5_r && !dz5_r, !(start5_r && end5_r), "path class clash")

endmodule

@@ design/swept_circle_collision_filter.sv @@
// ---------------------------------------------------------------------------
// swept_circle_collision_filter
// Tests a stream of circles against one reference circle, static or swept.
// ---------------------------------------------------------------------------
// One request per cycle enters and one hit flag leaves per cycle while out_ready
// is high; from acceptance to result a request crosses the seven-stage pipeline
// (differences, products, sums, case flags, split wide products, product sums,
// hit select). Each stage holds its own request under backpressure, so empty
// stages keep filling while a result waits. Write the reference circle over
// the APB port only while no request is in flight.
module swept_circle_collision_filter
  import sccf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [AddrW-1:0]   paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_mode,
  input  logic signed [23:0] in_b_cur_x,
  input  logic signed [23:0] in_b_cur_y,
  input  logic signed [23:0] in_b_prev_x,
  input  logic signed [23:0] in_b_prev_y,
  input  logic [15:0]        in_b_rad,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_hit
);

  ref_circle_t ref_w;
  geom_t       geom_w;
  logic        geom_valid;
  logic        geom_ready;

  sccf_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .ref_o   (ref_w)
  );

  sccf_geom u_geom (
    .clk         (clk),
    .rst_n       (rst_n),
    .ref_i       (ref_w),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_mode     (in_mode),
    .in_b_cur_x  (in_b_cur_x),
    .in_b_cur_y  (in_b_cur_y),
    .in_b_prev_x (in_b_prev_x),
    .in_b_prev_y (in_b_prev_y),
    .in_b_rad    (in_b_rad),
    .out_valid   (geom_valid),
    .out_ready   (geom_ready),
    .out_geom    (geom_w)
  );

  sccf_decide u_decide (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (geom_valid),
    .in_ready  (geom_ready),
    .in_geom   (geom_w),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_hit   (out_hit)
  );

endmodule
